FILE: hw/rtl/kcf_pkg.sv
// Shared types and constants of the key chatter filter.
package kcf_pkg;

  localparam int TIME_W   = 32;
  localparam int THRESH_W = 14;
  localparam int COUNT_W  = 16;
  localparam int CODE_W   = 8;
  localparam int ALU_W    = 32;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 14'd85;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 16'hFFFF;

  // Event kinds.
  localparam logic REQ_DOWN = 1'b0;
  localparam logic REQ_UP   = 1'b1;

  // Register word index of the threshold register.
  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic              req_type;
    logic [CODE_W-1:0] key_code;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic               pass_event;
    logic               new_key;
    logic [COUNT_W-1:0] chatter_total;
  } res_t;

  typedef struct packed {
    logic valid;
    logic pressed;
  } flags_t;

  typedef struct packed {
    logic [TIME_W-1:0]   last_press_ms;
    logic [THRESH_W-1:0] threshold_ms;
    logic [COUNT_W-1:0]  chatter_count;
  } entry_t;

  // Operation of the shared adder.
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             carry;
    logic [ALU_W-1:0] sum;
  } alu_res_t;

endpackage

FILE: hw/rtl/kcf_alu.sv
// Shared add/subtract unit with carry out, used for elapsed time, compare and count.
module kcf_alu
  import kcf_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   total;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.sub};

  // For a subtraction a carry out of zero means a borrow, that is a < b.
  assign res.carry = total[ALU_W];
  assign res.sum   = total[ALU_W-1:0];

endmodule

FILE: hw/rtl/kcf_table.sv
// Per-key table: a flag memory and an entry memory, one address, registered reads.
module kcf_table
  import kcf_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] addr,
  input  logic             rd_en,
  input  logic             flag_we,
  input  flags_t           flag_wdata,
  input  logic             entry_we,
  input  entry_t           entry_wdata,
  output flags_t           flag_rdata,
  output entry_t           entry_rdata
);

  flags_t flag_mem  [DEPTH];
  entry_t entry_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[addr] <= flag_wdata;
    end
    if (rd_en) begin
      flag_rdata <= flag_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[addr] <= entry_wdata;
    end
    if (rd_en) begin
      entry_rdata <= entry_mem[addr];
    end
  end

endmodule

FILE: hw/rtl/key_chatter_filter.sv
// Top level of the key chatter filter: sequencer, configuration register and result word.
// A result word is strobed after its event passes S_READ and S_EVAL, or, for a key-down on a
// known released key, after S_SUB, S_CMP and S_INC as well, three more passes through the shared adder.
// A new event is taken only while idle; start is taken again in the cycle of the strobe.
// Reset (rst_n, synchronous) sets the threshold to 85 ms and then sweeps the flag memory
// with busy high; configuration writes are taken during that sweep.
// Results cannot be stalled: each word is on out_res for exactly the cycle out_valid is high.
module key_chatter_filter
  import kcf_pkg::*;
#(
  parameter int KEY_CODES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Event channel
  input  logic        start,
  output logic        busy,
  input  req_t        in_req,
  // Result channel
  output logic        out_valid,
  output res_t        out_res,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(KEY_CODES);
  // Wide enough to hold both any key code and the table depth for the range check.
  localparam int CMP_W = (IDX_W + 1 > CODE_W) ? IDX_W + 1 : CODE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_CODES - 1);

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_SUB   = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_INC   = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [THRESH_W-1:0] threshold_r, threshold_nxt;
  req_t                req_r, req_nxt;
  logic                in_range_r, in_range_nxt;
  logic [TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic                less_r, less_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;

  logic             accept;
  logic             cfg_write;
  logic [IDX_W-1:0] tbl_addr;
  logic             tbl_rd_en;
  logic             flag_we;
  flags_t           flag_wdata;
  logic             entry_we;
  entry_t           entry_wdata;
  flags_t           flag_rdata;
  entry_t           entry_rdata;
  alu_req_t         alu_req;
  alu_res_t         alu_res;
  logic [COUNT_W-1:0] cnt_new;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // ------------------------------------------------------------------------
  // Configuration port. Only register word 0 exists; the byte offset bits of
  // paddr are ignored and any other word reads as zero and ignores writes.
  // ------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    threshold_nxt = threshold_r;
    if (cfg_write && (paddr[2] == REG_THRESHOLD)) begin
      threshold_nxt = pwdata[THRESH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_THRESHOLD) begin
      prdata = {{(32 - THRESH_W){1'b0}}, threshold_r};
    end
  end

  // ------------------------------------------------------------------------
  // Per-key table. During the sweep after reset the clear counter addresses
  // the flag memory; otherwise the latched key code does.
  // ------------------------------------------------------------------------
  assign tbl_addr  = (state_r == S_CLEAR) ? clr_cnt_r : IDX_W'(req_r.key_code);
  assign tbl_rd_en = (state_r == S_READ);

  kcf_table #(
    .DEPTH (KEY_CODES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk         (clk),
    .addr        (tbl_addr),
    .rd_en       (tbl_rd_en),
    .flag_we     (flag_we),
    .flag_wdata  (flag_wdata),
    .entry_we    (entry_we),
    .entry_wdata (entry_wdata),
    .flag_rdata  (flag_rdata),
    .entry_rdata (entry_rdata)
  );

  // ------------------------------------------------------------------------
  // Shared adder. The sequencer steers it through three jobs for a press of a
  // released key: elapsed = now - last press, then elapsed - threshold (the
  // borrow gives "inside the chatter window"), then count + 1.
  // ------------------------------------------------------------------------
  always_comb begin
    alu_req = '0;
    case (state_r)
      S_SUB: begin
        alu_req.sub = 1'b1;
        alu_req.a   = req_r.now_ms;
        alu_req.b   = entry_rdata.last_press_ms;
      end
      S_CMP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = elapsed_r;
        alu_req.b   = ALU_W'(entry_rdata.threshold_ms);
      end
      S_INC: begin
        alu_req.sub = 1'b0;
        alu_req.a   = ALU_W'(entry_rdata.chatter_count);
        alu_req.b   = ALU_W'(1);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  kcf_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // The count saturates: at its maximum the increment is simply not taken.
  assign cnt_new = (less_r && (entry_rdata.chatter_count != COUNT_MAX)) ?
                   alu_res.sum[COUNT_W-1:0] : entry_rdata.chatter_count;

  // ------------------------------------------------------------------------
  // Sequencer.
  // ------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    in_range_nxt  = in_range_r;
    elapsed_nxt   = elapsed_r;
    less_nxt      = less_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    flag_we       = 1'b0;
    flag_wdata    = '0;
    entry_we      = 1'b0;
    entry_wdata   = '0;

    case (state_r)
      S_CLEAR: begin
        // Mark every key unseen and released, one entry per cycle.
        flag_we     = 1'b1;
        flag_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          req_nxt      = in_req;
          in_range_nxt = CMP_W'(in_req.key_code) < CMP_W'(KEY_CODES);
          state_nxt    = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        out_res_nxt.pass_event    = 1'b1;
        out_res_nxt.new_key       = 1'b0;
        out_res_nxt.chatter_total = '0;
        state_nxt                 = S_IDLE;
        out_valid_nxt             = 1'b1;
        if (!in_range_r) begin
          // A code beyond the table passes without touching it.
          out_res_nxt.chatter_total = '0;
        end else if (req_r.req_type == REQ_UP) begin
          if (flag_rdata.valid) begin
            flag_we                   = 1'b1;
            flag_wdata.valid          = 1'b1;
            flag_wdata.pressed        = 1'b0;
            out_res_nxt.chatter_total = entry_rdata.chatter_count;
          end
        end else if (!flag_rdata.valid) begin
          // First key-down of an unseen key creates its entry, released.
          flag_we                   = 1'b1;
          flag_wdata.valid          = 1'b1;
          flag_wdata.pressed        = 1'b0;
          entry_we                  = 1'b1;
          entry_wdata.last_press_ms = req_r.now_ms;
          entry_wdata.threshold_ms  = threshold_r;
          entry_wdata.chatter_count = '0;
          out_res_nxt.new_key       = 1'b1;
        end else if (flag_rdata.pressed) begin
          // Key already held: passed, nothing changes.
          out_res_nxt.chatter_total = entry_rdata.chatter_count;
        end else begin
          // Press of a released key: time it against the entry's window.
          out_valid_nxt = 1'b0;
          state_nxt     = S_SUB;
        end
      end

      S_SUB: begin
        elapsed_nxt = alu_res.sum[TIME_W-1:0];
        state_nxt   = S_CMP;
      end

      S_CMP: begin
        less_nxt  = !alu_res.carry;
        state_nxt = S_INC;
      end

      S_INC: begin
        flag_we                   = 1'b1;
        flag_wdata.valid          = 1'b1;
        flag_wdata.pressed        = 1'b1;
        entry_we                  = 1'b1;
        entry_wdata.last_press_ms = req_r.now_ms;
        entry_wdata.threshold_ms  = entry_rdata.threshold_ms;
        entry_wdata.chatter_count = cnt_new;
        out_res_nxt.pass_event    = !less_r;
        out_res_nxt.new_key       = 1'b0;
        out_res_nxt.chatter_total = cnt_new;
        out_valid_nxt             = 1'b1;
        state_nxt                 = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      threshold_r <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      threshold_r <= threshold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    in_range_r <= in_range_nxt;
    elapsed_r  <= elapsed_nxt;
    less_r     <= less_nxt;
    out_res_r  <= out_res_nxt;
  end

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------

  // No result word can appear in the cycle right after an event is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid)
    else $error("result word strobed one cycle after accept");

  // Only the timed press of a released key can block an event.
  a_block_from_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.pass_event) |-> $past(state_r == S_INC))
    else $error("event blocked outside the timing path");

  // The sweep after reset ends only after the last table entry is cleared.
  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == S_CLEAR) && (state_r != S_CLEAR)) |-> ($past(clr_cnt_r) == LAST_IDX))
    else $error("flag sweep ended early");

endmodule
